/* rtl/ucfd_pkg.sv */
// Shared types, codes and the CRC-16 byte update for the UART channel frame deframer.
// Used by ucfd_parser and uart_channel_frame_deframer; depends on nothing else.
package ucfd_pkg;

	// Result kinds.
	localparam logic [2:0] KIND_DATA     = 3'd0;
	localparam logic [2:0] KIND_GOOD     = 3'd1;
	localparam logic [2:0] KIND_CRC_BAD  = 3'd2;
	localparam logic [2:0] KIND_BAD_CHAN = 3'd3;
	localparam logic [2:0] KIND_BAD_LEN  = 3'd4;

	// Routes of a good frame.
	localparam logic [1:0] ROUTE_TC        = 2'd0;
	localparam logic [1:0] ROUTE_PAYLOAD   = 2'd1;
	localparam logic [1:0] ROUTE_RF_STATUS = 2'd2;
	localparam logic [1:0] ROUTE_LOCAL     = 2'd3;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CHAN_TELECOMMAND = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CHAN_PAYLOAD     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CHAN_LOCAL       = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_RF_STATUS_TARGET = 3'd6;

	// Register reset values.
	localparam logic [7:0]  RST_SYNC_FIRST       = 8'd235;
	localparam logic [7:0]  RST_SYNC_SECOND      = 8'd144;
	localparam logic [15:0] RST_MAX_PAYLOAD      = 16'd1024;
	localparam logic [7:0]  RST_CHAN_TELECOMMAND = 8'd0;
	localparam logic [7:0]  RST_CHAN_PAYLOAD     = 8'd1;
	localparam logic [7:0]  RST_CHAN_LOCAL       = 8'd2;
	localparam logic [7:0]  RST_RF_STATUS_TARGET = 8'd0;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [15:0] max_payload;
		logic [7:0]  chan_telecommand;
		logic [7:0]  chan_payload;
		logic [7:0]  chan_local;
		logic [7:0]  rf_status_target;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [7:0]  channel_id;
		logic [1:0]  route;
		logic [15:0] frame_length;
		logic [31:0] good_count;
		logic [31:0] drop_count;
	} result_t;

	// CRC-16/CCITT-FALSE update by one byte, MSB first.
	function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == COUNT_MAX) ? v : v + 32'd1;
	endfunction

endpackage

/* rtl/ucfd_parser.sv */
// Frame parser state machine: sync, channel and length checks, running CRC and routing.
// Depends on ucfd_pkg; produces at most one result per byte stepped in.
module ucfd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	input  ucfd_pkg::cfg_t     cfg,
	output logic               res_valid,
	output ucfd_pkg::result_t  res
);

	typedef enum logic [2:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_CHAN,
		PH_LENLO,
		PH_LENHI,
		PH_DATA,
		PH_CRCLO,
		PH_CRCHI
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  chan_q, chan_d;
	logic [15:0] len_q, len_d;
	logic [15:0] pos_q, pos_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  first_q, first_d;
	logic [31:0] good_q, good_d;
	logic [31:0] drop_q, drop_d;

	logic [15:0] len_new;
	logic [15:0] pos_inc;
	logic        chan_match;

	assign len_new    = {rx_byte, len_q[7:0]};
	assign pos_inc    = pos_q + 16'd1;
	assign chan_match = (rx_byte == cfg.chan_telecommand) || (rx_byte == cfg.chan_payload)
		|| (rx_byte == cfg.chan_local);

	always_comb begin
		phase_d   = phase_q;
		chan_d    = chan_q;
		len_d     = len_q;
		pos_d     = pos_q;
		crc_lo_d  = crc_lo_q;
		crc_d     = crc_q;
		first_d   = first_q;
		good_d    = good_q;
		drop_d    = drop_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_SYNC1: begin
				if (rx_byte == cfg.sync_first) begin
					phase_d = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				// A wrong second sync byte is dropped, not retried as a first sync.
				phase_d = (rx_byte == cfg.sync_second) ? PH_CHAN : PH_SYNC1;
			end
			PH_CHAN: begin
				if (chan_match) begin
					chan_d  = rx_byte;
					phase_d = PH_LENLO;
				end else begin
					drop_d         = ucfd_pkg::sat_inc(drop_q);
					phase_d        = PH_SYNC1;
					res_valid      = 1'b1;
					res.kind       = ucfd_pkg::KIND_BAD_CHAN;
					res.channel_id = rx_byte;
				end
			end
			PH_LENLO: begin
				len_d   = {8'h00, rx_byte};
				phase_d = PH_LENHI;
			end
			PH_LENHI: begin
				len_d = len_new;
				if (len_new == 16'd0 || len_new > cfg.max_payload) begin
					drop_d           = ucfd_pkg::sat_inc(drop_q);
					phase_d          = PH_SYNC1;
					res_valid        = 1'b1;
					res.kind         = ucfd_pkg::KIND_BAD_LEN;
					res.channel_id   = chan_q;
					res.frame_length = len_new;
				end else begin
					pos_d   = 16'd0;
					crc_d   = ucfd_pkg::CRC_INIT;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (pos_q == 16'd0) begin
					first_d = rx_byte;
				end
				crc_d = ucfd_pkg::crc_step(crc_q, rx_byte);
				pos_d = pos_inc;
				if (pos_inc >= len_q) begin
					phase_d = PH_CRCLO;
				end
				res_valid        = 1'b1;
				res.kind         = ucfd_pkg::KIND_DATA;
				res.data_byte    = rx_byte;
				res.byte_index   = pos_q;
				res.channel_id   = chan_q;
				res.frame_length = len_q;
			end
			PH_CRCLO: begin
				crc_lo_d = rx_byte;
				phase_d  = PH_CRCHI;
			end
			PH_CRCHI: begin
				phase_d          = PH_SYNC1;
				res_valid        = 1'b1;
				res.channel_id   = chan_q;
				res.frame_length = len_q;
				if ({rx_byte, crc_lo_q} == crc_q) begin
					good_d   = ucfd_pkg::sat_inc(good_q);
					res.kind = ucfd_pkg::KIND_GOOD;
					// Channel registers may have changed mid-frame; no match routes as telecommand.
					if (chan_q == cfg.chan_telecommand) begin
						res.route = ucfd_pkg::ROUTE_TC;
					end else if (chan_q == cfg.chan_payload) begin
						res.route = ucfd_pkg::ROUTE_PAYLOAD;
					end else if (chan_q == cfg.chan_local) begin
						res.route = (first_q == cfg.rf_status_target) ?
							ucfd_pkg::ROUTE_RF_STATUS : ucfd_pkg::ROUTE_LOCAL;
					end else begin
						res.route = ucfd_pkg::ROUTE_TC;
					end
				end else begin
					drop_d   = ucfd_pkg::sat_inc(drop_q);
					res.kind = ucfd_pkg::KIND_CRC_BAD;
				end
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase
		res.good_count = good_d;
		res.drop_count = drop_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			chan_q   <= '0;
			len_q    <= '0;
			pos_q    <= '0;
			crc_lo_q <= '0;
			crc_q    <= ucfd_pkg::CRC_INIT;
			first_q  <= '0;
			good_q   <= '0;
			drop_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			chan_q   <= chan_d;
			len_q    <= len_d;
			pos_q    <= pos_d;
			crc_lo_q <= crc_lo_d;
			crc_q    <= crc_d;
			first_q  <= first_d;
			good_q   <= good_d;
			drop_q   <= drop_d;
		end
	end

endmodule

/* rtl/uart_channel_frame_deframer.sv */
// Top level of the UART channel frame deframer: handshakes, configuration registers,
// input and result registers around ucfd_parser. Depends on ucfd_pkg and ucfd_parser.
// Path: an accepted byte is held in the input register; the parser steps it into the result
// register, and so presents its beat, once that register is free or its beat is taken.
// Throughput: one byte per cycle while out_ready is high, set by the parser step and CRC update.
// Reset: arst_n clears the parser, zeroes both counters, empties both stage registers and
// loads the configuration reset values.
module uart_channel_frame_deframer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         rx_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         kind,
	output logic [7:0]                         data_byte,
	output logic [15:0]                        byte_index,
	output logic [7:0]                         channel_id,
	output logic [1:0]                         route,
	output logic [15:0]                        frame_length,
	output logic [31:0]                        good_count,
	output logic [31:0]                        drop_count,
	input  logic                               cfg_we,
	input  logic [ucfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ucfd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	ucfd_pkg::cfg_t    cfg_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	logic              res_valid;
	ucfd_pkg::result_t res;
	logic              valid_s2;
	ucfd_pkg::result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first       <= ucfd_pkg::RST_SYNC_FIRST;
			cfg_q.sync_second      <= ucfd_pkg::RST_SYNC_SECOND;
			cfg_q.max_payload      <= ucfd_pkg::RST_MAX_PAYLOAD;
			cfg_q.chan_telecommand <= ucfd_pkg::RST_CHAN_TELECOMMAND;
			cfg_q.chan_payload     <= ucfd_pkg::RST_CHAN_PAYLOAD;
			cfg_q.chan_local       <= ucfd_pkg::RST_CHAN_LOCAL;
			cfg_q.rf_status_target <= ucfd_pkg::RST_RF_STATUS_TARGET;
		end else if (cfg_we) begin
			case (cfg_index)
				ucfd_pkg::REG_SYNC_FIRST:       cfg_q.sync_first       <= cfg_wdata[7:0];
				ucfd_pkg::REG_SYNC_SECOND:      cfg_q.sync_second      <= cfg_wdata[7:0];
				ucfd_pkg::REG_MAX_PAYLOAD:      cfg_q.max_payload      <= cfg_wdata;
				ucfd_pkg::REG_CHAN_TELECOMMAND: cfg_q.chan_telecommand <= cfg_wdata[7:0];
				ucfd_pkg::REG_CHAN_PAYLOAD:     cfg_q.chan_payload     <= cfg_wdata[7:0];
				ucfd_pkg::REG_CHAN_LOCAL:       cfg_q.chan_local       <= cfg_wdata[7:0];
				ucfd_pkg::REG_RF_STATUS_TARGET: cfg_q.rf_status_target <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// The held byte is parsed once the result register is free or its beat is taken.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	ucfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign kind         = res_s2.kind;
	assign data_byte    = res_s2.data_byte;
	assign byte_index   = res_s2.byte_index;
	assign channel_id   = res_s2.channel_id;
	assign route        = res_s2.route;
	assign frame_length = res_s2.frame_length;
	assign good_count   = res_s2.good_count;
	assign drop_count   = res_s2.drop_count;

`ifndef SYNTHESIS
	// Only payload beats carry a data byte and a position.
	a_data_only_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != ucfd_pkg::KIND_DATA |-> data_byte == 8'd0 && byte_index == 16'd0)
		else $error("data_byte or byte_index set on a non-payload beat");

	// A route is given only with a good verdict.
	a_route_only_on_good: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != ucfd_pkg::KIND_GOOD |-> route == ucfd_pkg::ROUTE_TC)
		else $error("route set on a beat that is not a good frame");

	// A payload position always lies inside the announced length.
	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == ucfd_pkg::KIND_DATA |-> byte_index < frame_length)
		else $error("payload byte_index beyond frame_length");

	// The input side stalls only while a byte waits in the input register.
	a_stall_needs_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without a blocked byte");
`endif

endmodule
